[rtl/core/pmvg_pkg.sv]
// shared constants and types for the parametric mesh vertex generator
`timescale 1ns / 1ps

package pmvg_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int PHASE_BITS_DEF = 16;

    // pi/2 in q30, split for two narrow multiplies
    localparam logic [15:0] HALFPI_LO = 16'hED51;
    localparam logic [14:0] HALFPI_HI = 15'h6487;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int TAYLOR_STEPS = 6;

    localparam logic [7:0] TAYLOR_DIV [TAYLOR_STEPS] = '{
        8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };

    // floor(2^32 / divisor), low by at most one after the multiply
    localparam logic [29:0] TAYLOR_RECIP [TAYLOR_STEPS] = '{
        30'(33'h1_0000_0000 / 33'd156),
        30'(33'h1_0000_0000 / 33'd110),
        30'(33'h1_0000_0000 / 33'd72),
        30'(33'h1_0000_0000 / 33'd42),
        30'(33'h1_0000_0000 / 33'd20),
        30'(33'h1_0000_0000 / 33'd6)
    };

    localparam int SINE_LATENCY = 24;

    typedef enum logic [2:0] {
        REG_SHAPE_MODE   = 3'd0,
        REG_ROW_COUNT    = 3'd1,
        REG_COLUMN_COUNT = 3'd2,
        REG_RING_RADIUS  = 3'd3,
        REG_TUBE_RADIUS  = 3'd4,
        REG_TILE_SCALE   = 3'd5
    } reg_addr_t;

endpackage

[rtl/core/pmvg_delay.sv]
// enable-gated shift line that aligns side data with the pipeline
`timescale 1ns / 1ps

module pmvg_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

[rtl/core/pmvg_div.sv]
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module pmvg_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 10,
    parameter int Q_W   = 17
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quo
);

    // numerator shifted right by Q_W must stay below the divisor
    logic [DEN_W-1:0] rem_reg  [0:Q_W];
    logic [Q_W-1:0]   work_reg [0:Q_W];
    logic [DEN_W-1:0] den_reg  [0:Q_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(num >> Q_W);
            work_reg[0] <= num[Q_W-1:0];
            den_reg[0]  <= den;
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           ge;

        assign trial = {rem_reg[k-1], work_reg[k-1][Q_W-1]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? DEN_W'(trial - {1'b0, den_reg[k-1]}) : DEN_W'(trial);
                work_reg[k] <= {work_reg[k-1][Q_W-2:0], ge};
            end
        end

        if (k < Q_W)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo = work_reg[Q_W];

endmodule

[rtl/core/pmvg_sine.sv]
// pipelined q1.14 sine of a phase, quadrant fold plus taylor series in q30
`timescale 1ns / 1ps

module pmvg_sine #(
    parameter int PHASE_BITS = pmvg_pkg::PHASE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [PHASE_BITS-1:0]   phase,
    output logic signed [15:0]      sine
);

    import pmvg_pkg::*;

    localparam int QB = PHASE_BITS - 2;
    localparam int AW = QB + 1;
    localparam logic [AW-1:0] QUARTER = AW'(1) << QB;
    localparam int LAST = 3 * TAYLOR_STEPS;
    localparam int X2_LAST = 3 * (TAYLOR_STEPS - 1);

    logic [AW-1:0]    a_reg;
    logic [AW-1:0]    a_next;
    logic             neg1_reg, neg2_reg, neg3_reg;
    logic [AW+15:0]   plo_reg;
    logic [AW+14:0]   phi_reg;
    logic [30:0]      x_reg;
    logic [30:0]      x_p   [0:LAST];
    logic [31:0]      x2_p  [0:X2_LAST];
    logic             neg_p [0:LAST];
    logic [31:0]      m1_reg [0:TAYLOR_STEPS-1];
    logic [31:0]      m2_reg [0:TAYLOR_STEPS-1];
    logic [29:0]      q0_reg [0:TAYLOR_STEPS-1];
    logic [30:0]      t_reg  [0:TAYLOR_STEPS-1];
    logic [61:0]      sq;
    logic [61:0]      fin_prod;
    logic [31:0]      fin_reg;
    logic             negf_reg;
    logic [15:0]      mag;
    logic signed [15:0] sine_reg;

    // odd quadrants run the quarter wave backwards
    assign a_next = phase[QB] ? AW'(QUARTER - {1'b0, phase[QB-1:0]})
                              : {1'b0, phase[QB-1:0]};
    assign sq = 62'(x_reg) * 62'(x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a_next;
            neg1_reg <= phase[PHASE_BITS-1];
            plo_reg  <= (AW+16)'(a_reg) * (AW+16)'(HALFPI_LO);
            phi_reg  <= (AW+15)'(a_reg) * (AW+15)'(HALFPI_HI);
            neg2_reg <= neg1_reg;
            x_reg    <= 31'(({phi_reg, 16'b0} + (AW+31)'(plo_reg)) >> QB);
            neg3_reg <= neg2_reg;
            x_p[0]   <= x_reg;
            x2_p[0]  <= sq[61:30];
            neg_p[0] <= neg3_reg;
        end
    end

    for (genvar k = 0; k < TAYLOR_STEPS; k++)
    begin : g_taylor
        localparam int J = 3 * k;
        logic [30:0] t_in;
        logic [62:0] mp;
        logic [61:0] qp;
        logic [37:0] qd;
        logic [31:0] rm;
        logic [29:0] qq;

        if (k == 0)
        begin : g_first
            assign t_in = ONE_Q30;
        end
        else
        begin : g_rest
            assign t_in = t_reg[k-1];
        end

        assign mp = 63'(x2_p[J]) * 63'(t_in);
        assign qp = 62'(m1_reg[k]) * 62'(TAYLOR_RECIP[k]);
        assign qd = 38'(q0_reg[k]) * 38'(TAYLOR_DIV[k]);
        assign rm = m2_reg[k] - qd[31:0];
        assign qq = q0_reg[k] + 30'(rm >= 32'(TAYLOR_DIV[k]));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m1_reg[k]  <= mp[61:30];
                q0_reg[k]  <= qp[61:32];
                m2_reg[k]  <= m1_reg[k];
                t_reg[k]   <= ONE_Q30 - 31'(qq);
                x_p[J+1]   <= x_p[J];
                x_p[J+2]   <= x_p[J+1];
                x_p[J+3]   <= x_p[J+2];
                neg_p[J+1] <= neg_p[J];
                neg_p[J+2] <= neg_p[J+1];
                neg_p[J+3] <= neg_p[J+2];
            end
        end

        if (k < TAYLOR_STEPS - 1)
        begin : g_x2
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x2_p[J+1] <= x2_p[J];
                    x2_p[J+2] <= x2_p[J+1];
                    x2_p[J+3] <= x2_p[J+2];
                end
            end
        end
    end

    assign fin_prod = 62'(x_p[LAST]) * 62'(t_reg[TAYLOR_STEPS-1]);
    assign mag      = 16'((fin_reg + 32'd32768) >> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg  <= fin_prod[61:30];
            negf_reg <= neg_p[LAST];
            sine_reg <= negf_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign sine = sine_reg;

endmodule

[rtl/core/parametric_mesh_vertex_generator.sv]
// top level: config registers, grid clamp, phase and texture dividers, vertex math
`timescale 1ns / 1ps

// One grid point enters per clock and one vertex leaves per clock while the
// output is not stalled. Each beat passes the grid clamp, then the phase
// dividers, which resolve one quotient bit per stage, then the 24-stage sine
// unit (quadrant fold, six taylor terms of three stages each) and then four
// stages of products, rounding and saturation.
// A stall on the output freezes every stage at once; input is taken whenever
// the output register is empty or being drained. Write configuration only
// while no beat is in flight.
module parametric_mesh_vertex_generator #(
    parameter int INDEX_BITS = pmvg_pkg::INDEX_BITS_DEF,
    parameter int PHASE_BITS = pmvg_pkg::PHASE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // row_index, column_index
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
    // own_index, next_row_index, quad_valid
    output logic [175:0] m_tdata
);

    import pmvg_pkg::*;

    localparam int PB  = PHASE_BITS;
    localparam int NW  = 10 + PB;
    localparam int QW  = PB + 1;
    localparam int T   = PB + 31;
    localparam logic [9:0]    IDX_MASK  = 10'((1 << INDEX_BITS) - 1);
    localparam logic [PB-1:0] QUARTER_P = PB'(1) << (PB - 2);

    function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] v,
                                                   input int sh);
        logic signed [47:0] one;
        one = 48'sd1;
        return (v + (one <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -48'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = 16'(v);
        end
        return r;
    endfunction

    // configuration
    logic        shape_mode_reg;
    logic [9:0]  row_count_reg;
    logic [9:0]  column_count_reg;
    logic [14:0] ring_radius_reg;
    logic [14:0] tube_radius_reg;
    logic [15:0] tile_scale_reg;
    logic        wr_en;
    reg_addr_t   addr;

    assign addr   = reg_addr_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg   <= 1'b0;
            row_count_reg    <= 10'd20;
            column_count_reg <= 10'd30;
            ring_radius_reg  <= 15'd4915;
            tube_radius_reg  <= 15'd1638;
            tile_scale_reg   <= 16'd256;
        end
        else if (wr_en)
        begin
            case (addr)
                REG_SHAPE_MODE:   shape_mode_reg   <= pwdata[0];
                REG_ROW_COUNT:    row_count_reg    <= pwdata[9:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[9:0];
                REG_RING_RADIUS:  ring_radius_reg  <= pwdata[14:0];
                REG_TUBE_RADIUS:  tube_radius_reg  <= pwdata[14:0];
                REG_TILE_SCALE:   tile_scale_reg   <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (addr)
            REG_SHAPE_MODE:   prdata = {31'b0, shape_mode_reg};
            REG_ROW_COUNT:    prdata = {22'b0, row_count_reg};
            REG_COLUMN_COUNT: prdata = {22'b0, column_count_reg};
            REG_RING_RADIUS:  prdata = {17'b0, ring_radius_reg};
            REG_TUBE_RADIUS:  prdata = {17'b0, tube_radius_reg};
            REG_TILE_SCALE:   prdata = {16'b0, tile_scale_reg};
            default:          prdata = 32'b0;
        endcase
    end

    // flow control: whole pipeline moves together
    logic         en;
    logic [T-1:0] vld_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[T-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[T-2:0], s_tvalid};
        end
    end

    // effective counts, zero acts as one
    logic [9:0] rows_m, cols_m, rows_e, cols_e;
    logic [9:0] row_in, col_in;

    assign rows_m = row_count_reg & IDX_MASK;
    assign cols_m = column_count_reg & IDX_MASK;
    assign rows_e = (rows_m == 10'd0) ? 10'd1 : rows_m;
    assign cols_e = (cols_m == 10'd0) ? 10'd1 : cols_m;
    assign row_in = s_tdata[9:0] & IDX_MASK;
    assign col_in = s_tdata[19:10] & IDX_MASK;

    // stage a: clamped grid point
    logic [9:0] row_a_reg, col_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            row_a_reg <= (row_in > rows_e) ? rows_e : row_in;
            col_a_reg <= (col_in > cols_e) ? cols_e : col_in;
        end
    end

    // phase dividers
    logic [NW-1:0] num_r, num_c;
    logic [QW-1:0] quo_r, quo_c;
    logic [PB-1:0] ph1, ph2;

    assign num_r = shape_mode_reg ? (NW'(row_a_reg) << PB) : (NW'(row_a_reg) << (PB - 1));
    assign num_c = NW'(col_a_reg) << PB;

    pmvg_div #(.NUM_W(NW), .DEN_W(10), .Q_W(QW)) u_div_row (
        .clk(clk), .en(en), .num(num_r), .den(rows_e), .quo(quo_r)
    );

    pmvg_div #(.NUM_W(NW), .DEN_W(10), .Q_W(QW)) u_div_col (
        .clk(clk), .en(en), .num(num_c), .den(cols_e), .quo(quo_c)
    );

    assign ph1 = quo_r[PB-1:0];
    assign ph2 = quo_c[PB-1:0];

    logic signed [15:0] sin1, cos1, sin2, cos2;

    pmvg_sine #(.PHASE_BITS(PB)) u_sin1 (
        .clk(clk), .en(en), .phase(ph1), .sine(sin1)
    );

    pmvg_sine #(.PHASE_BITS(PB)) u_cos1 (
        .clk(clk), .en(en), .phase(ph1 + QUARTER_P), .sine(cos1)
    );

    pmvg_sine #(.PHASE_BITS(PB)) u_sin2 (
        .clk(clk), .en(en), .phase(ph2), .sine(sin2)
    );

    pmvg_sine #(.PHASE_BITS(PB)) u_cos2 (
        .clk(clk), .en(en), .phase(ph2 + QUARTER_P), .sine(cos2)
    );

    // stage b: texture numerators, vertex indices
    logic [9:0]  idx_u, idx_v, cnt_u, cnt_v;
    logic [26:0] tnum_u_reg, tnum_v_reg;
    logic [10:0] tden_u_reg, tden_v_reg;
    logic [20:0] own_b, own_b_reg, next_b_reg;
    logic        quad_b_reg;

    assign idx_u = shape_mode_reg ? row_a_reg : col_a_reg;
    assign idx_v = shape_mode_reg ? col_a_reg : row_a_reg;
    assign cnt_u = shape_mode_reg ? rows_e : cols_e;
    assign cnt_v = shape_mode_reg ? cols_e : rows_e;
    assign own_b = 21'(row_a_reg) * 21'({1'b0, cols_e} + 11'd1) + 21'(col_a_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tnum_u_reg <= ((27'(idx_u) * 27'(tile_scale_reg)) << 1) + 27'(cnt_u);
            tnum_v_reg <= ((27'(idx_v) * 27'(tile_scale_reg)) << 1) + 27'(cnt_v);
            tden_u_reg <= {cnt_u, 1'b0};
            tden_v_reg <= {cnt_v, 1'b0};
            own_b_reg  <= own_b;
            next_b_reg <= own_b + 21'(cols_e) + 21'd1;
            quad_b_reg <= (row_a_reg < rows_e) && (col_a_reg < cols_e);
        end
    end

    logic [15:0] tu_q, tv_q;

    pmvg_div #(.NUM_W(27), .DEN_W(11), .Q_W(16)) u_div_tu (
        .clk(clk), .en(en), .num(tnum_u_reg), .den(tden_u_reg), .quo(tu_q)
    );

    pmvg_div #(.NUM_W(27), .DEN_W(11), .Q_W(16)) u_div_tv (
        .clk(clk), .en(en), .num(tnum_v_reg), .den(tden_v_reg), .quo(tv_q)
    );

    logic [31:0] tex_d;
    logic [42:0] idx_d;

    pmvg_delay #(.W(32), .DEPTH(PB + 11)) u_dly_tex (
        .clk(clk), .en(en), .din({tv_q, tu_q}), .dout(tex_d)
    );

    pmvg_delay #(.W(43), .DEPTH(PB + 28)) u_dly_idx (
        .clk(clk), .en(en), .din({quad_b_reg, next_b_reg, own_b_reg}), .dout(idx_d)
    );

    // p1: products of trig terms
    logic signed [31:0] ma_p1, mb_p1, rc_p1, rs_p1;
    logic signed [15:0] c1_p1, s1_p1, s2_p1;
    logic signed [15:0] tube_s;

    assign tube_s = $signed({1'b0, tube_radius_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_p1 <= cos2 * (shape_mode_reg ? cos1 : sin1);
            mb_p1 <= (shape_mode_reg ? cos2 : sin2) * sin1;
            rc_p1 <= tube_s * cos2;
            rs_p1 <= tube_s * sin2;
            c1_p1 <= cos1;
            s1_p1 <= sin1;
            s2_p1 <= sin2;
        end
    end

    // p2: rounding, torus radius
    logic signed [15:0] nx_p2, ny_p2, nz_p2, py_p2, pxs_p2, pzs_p2;
    logic signed [31:0] rad_p2;
    logic signed [15:0] c1_p2, s1_p2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_p2  <= 16'(rnd_shr(48'(ma_p1), 14));
            nz_p2  <= 16'(rnd_shr(48'(mb_p1), 14));
            pxs_p2 <= 16'(rnd_shr(48'(ma_p1), 15));
            pzs_p2 <= 16'(rnd_shr(48'(mb_p1), 15));
            ny_p2  <= shape_mode_reg ? s2_p1 : c1_p1;
            py_p2  <= shape_mode_reg ? sat16(rnd_shr(48'(rs_p1), 14))
                                     : 16'(rnd_shr(48'(c1_p1), 1));
            rad_p2 <= $signed({3'b0, ring_radius_reg, 14'b0}) + rc_p1;
            c1_p2  <= c1_p1;
            s1_p2  <= s1_p1;
        end
    end

    // p3: torus position products
    logic signed [47:0] pxt_p3, pzt_p3;
    logic signed [15:0] nx_p3, ny_p3, nz_p3, py_p3, pxs_p3, pzs_p3;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxt_p3 <= 48'(rad_p2) * 48'(c1_p2);
            pzt_p3 <= 48'(rad_p2) * 48'(s1_p2);
            nx_p3  <= nx_p2;
            ny_p3  <= ny_p2;
            nz_p3  <= nz_p2;
            py_p3  <= py_p2;
            pxs_p3 <= pxs_p2;
            pzs_p3 <= pzs_p2;
        end
    end

    // output register
    logic signed [15:0] px_reg, py_reg, pz_reg, nx_reg, ny_reg, nz_reg;
    logic [15:0]        tu_reg, tv_reg;
    logic [20:0]        own_reg, next_reg;
    logic               quad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= shape_mode_reg ? sat16(rnd_shr(pxt_p3, 28)) : pxs_p3;
            pz_reg   <= shape_mode_reg ? sat16(rnd_shr(pzt_p3, 28)) : pzs_p3;
            py_reg   <= py_p3;
            nx_reg   <= nx_p3;
            ny_reg   <= ny_p3;
            nz_reg   <= nz_p3;
            tu_reg   <= tex_d[15:0];
            tv_reg   <= tex_d[31:16];
            own_reg  <= idx_d[20:0];
            next_reg <= idx_d[41:21];
            quad_reg <= idx_d[42];
        end
    end

    assign m_tdata = {5'b0, quad_reg, next_reg, own_reg, tv_reg, tu_reg,
                      nz_reg, ny_reg, nx_reg, pz_reg, py_reg, px_reg};

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (ny_reg <= 16'sd16384 && ny_reg >= -16'sd16384))
        else $error("normal y out of unit range");

endmodule

[test/tb.sv]
// testbench for the parametric mesh vertex generator: directed table, random grid points
`timescale 1ns / 1ps

module tb;
    import pmvg_pkg::*;

    localparam int PH_BITS = 16;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        int row;
        int col;
        bit typed;
        int own;
        int next_row;
        bit quad;
    } grid_row_t;

    typedef struct {
        bit mode;
        int rows;
        int cols;
        int ring;
        int tube;
        int tile;
        bit quiet;
        bit hold;
    } mesh_setup_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic s_tvalid;
    logic s_tready;
    logic [23:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [175:0] m_tdata;

    bit cfg_mode;
    int cfg_rows;
    int cfg_cols;
    int cfg_ring;
    int cfg_tube;
    int cfg_tile;

    logic [175:0] vertex_queue[$];
    int mismatches;
    int hold_cycles;
    bit quiet;

    const int field_lo[11] = '{0, 16, 32, 48, 64, 80, 96, 112, 128, 149, 170};
    const int field_w[11] = '{16, 16, 16, 16, 16, 16, 16, 16, 21, 21, 1};
    const string field_name[11] = '{"pos_x", "pos_y", "pos_z", "normal_x", "normal_y",
        "normal_z", "tex_u", "tex_v", "own_index", "next_row_index", "quad_valid"};
    const longint unsigned taylor_d[6] = '{156, 110, 72, 42, 20, 6};

    parametric_mesh_vertex_generator u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint qsine(longint unsigned a);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        x = (a * 64'd1686629713) >> (PH_BITS - 2);
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int k = 0; k < 6; k++)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / taylor_d[k];
        return longint'((((x * t) >> 30) + (64'd1 << 15)) >> 16);
    endfunction

    function automatic longint sine_q14(longint unsigned phase);
        longint unsigned p;
        longint unsigned q;
        longint unsigned r;
        longint s;
        p = phase & ((64'd1 << PH_BITS) - 1);
        q = (p >> (PH_BITS - 2)) & 3;
        r = p & ((64'd1 << (PH_BITS - 2)) - 1);
        s = q[0] ? qsine((64'd1 << (PH_BITS - 2)) - r) : qsine(r);
        return q[1] ? -s : s;
    endfunction

    function automatic longint round_sh(longint p, int sh);
        longint q;
        q = p + (longint'(1) << (sh - 1));
        if (q >= 0)
            return q >>> sh;
        return -((-q + ((longint'(1) << sh) - 1)) >>> sh);
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint unsigned tex_q88(longint unsigned idx, longint unsigned cnt);
        longint unsigned v;
        v = (2 * idx * cfg_tile + cnt) / (2 * cnt);
        return v > 65535 ? 65535 : v;
    endfunction

    function automatic logic [175:0] mesh_vertex(int row_in, int col_in);
        longint unsigned rows;
        longint unsigned cols;
        longint unsigned row;
        longint unsigned col;
        longint unsigned ph_a;
        longint unsigned ph_b;
        longint unsigned own;
        longint sa, ca, sb, cb, xp, zp, rad;
        longint px, py, pz, nx, ny, nz;
        longint unsigned tu, tv;
        logic [175:0] w;
        rows = cfg_rows == 0 ? 1 : cfg_rows;
        cols = cfg_cols == 0 ? 1 : cfg_cols;
        row = row_in > rows ? rows : row_in;
        col = col_in > cols ? cols : col_in;
        ph_b = (col << PH_BITS) / cols;
        sb = sine_q14(ph_b);
        cb = sine_q14(ph_b + (64'd1 << (PH_BITS - 2)));
        if (!cfg_mode)
        begin
            ph_a = (row << (PH_BITS - 1)) / rows;
            sa = sine_q14(ph_a);
            ca = sine_q14(ph_a + (64'd1 << (PH_BITS - 2)));
            xp = cb * sa;
            zp = sb * sa;
            nx = round_sh(xp, 14);
            ny = ca;
            nz = round_sh(zp, 14);
            px = round_sh(xp, 15);
            py = round_sh(ca, 1);
            pz = round_sh(zp, 15);
            tu = tex_q88(col, cols);
            tv = tex_q88(row, rows);
        end
        else
        begin
            ph_a = (row << PH_BITS) / rows;
            sa = sine_q14(ph_a);
            ca = sine_q14(ph_a + (64'd1 << (PH_BITS - 2)));
            rad = (longint'(cfg_ring) << 14) + longint'(cfg_tube) * cb;
            px = clip16(round_sh(rad * ca, 28));
            py = clip16(round_sh(longint'(cfg_tube) * sb, 14));
            pz = clip16(round_sh(rad * sa, 28));
            nx = round_sh(ca * cb, 14);
            ny = sb;
            nz = round_sh(sa * cb, 14);
            tu = tex_q88(row, rows);
            tv = tex_q88(col, cols);
        end
        own = row * (cols + 1) + col;
        w = '0;
        w[15:0] = px[15:0];
        w[31:16] = py[15:0];
        w[47:32] = pz[15:0];
        w[63:48] = nx[15:0];
        w[79:64] = ny[15:0];
        w[95:80] = nz[15:0];
        w[111:96] = tu[15:0];
        w[127:112] = tv[15:0];
        w[148:128] = own[20:0];
        w[169:149] = own[20:0] + cols[20:0] + 21'd1;
        w[170] = row < rows && col < cols;
        return w;
    endfunction

    // output check
    always @(posedge clk)
    begin
        logic [175:0] exp_w;
        longint unsigned e;
        longint unsigned a;
        bit bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (vertex_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex beat %h", m_tdata);
            end
            else
            begin
                exp_w = vertex_queue.pop_front();
                bad = 1'b0;
                for (int f = 0; f < 11; f++)
                begin
                    e = 64'(exp_w >> field_lo[f]) & ((64'd1 << field_w[f]) - 1);
                    a = 64'(m_tdata >> field_lo[f]) & ((64'd1 << field_w[f]) - 1);
                    if (e != a)
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("%s: expected %0h got %0h", field_name[f], e, a);
                    end
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver backpressure
    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    task automatic reg_write(reg_addr_t idx, int value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setup(mesh_setup_t c);
        while (vertex_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        reg_write(REG_SHAPE_MODE, c.mode);
        reg_write(REG_ROW_COUNT, c.rows);
        reg_write(REG_COLUMN_COUNT, c.cols);
        reg_write(REG_RING_RADIUS, c.ring);
        reg_write(REG_TUBE_RADIUS, c.tube);
        reg_write(REG_TILE_SCALE, c.tile);
        cfg_mode = c.mode;
        cfg_rows = c.rows;
        cfg_cols = c.cols;
        cfg_ring = c.ring;
        cfg_tube = c.tube;
        cfg_tile = c.tile;
        quiet = c.quiet;
    endtask

    // drives one beat; valid stays high when no gap follows
    task automatic send_point(grid_row_t g);
        int gap;
        logic [175:0] w;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, 10'(g.col), 10'(g.row)};
        do
            @(posedge clk);
        while (!s_tready);
        w = mesh_vertex(g.row, g.col);
        if (g.typed)
        begin
            w[148:128] = 21'(g.own);
            w[169:149] = 21'(g.next_row);
            w[170] = g.quad;
        end
        vertex_queue.insert(vertex_queue.size(), w);
        @(negedge clk);
    endtask

    function automatic int pick_index(int cnt);
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, cnt);
        return $urandom_range(0, 1023);
    endfunction

    initial
    begin
        grid_row_t directed[] = '{
            '{0, 0, 1, 0, 31, 1},
            '{20, 30, 1, 650, 681, 0},
            '{1023, 1023, 1, 650, 681, 0},
            '{19, 29, 1, 618, 649, 1},
            '{0, 30, 1, 30, 61, 0},
            '{20, 0, 1, 620, 651, 0},
            '{10, 15, 0, 0, 0, 0},
            '{5, 7, 0, 0, 0, 0},
            '{15, 22, 0, 0, 0, 0},
            '{1, 1, 0, 0, 0, 0},
            '{682, 341, 0, 0, 0, 0},
            '{341, 682, 0, 0, 0, 0},
            '{512, 1, 0, 0, 0, 0},
            '{1, 512, 0, 0, 0, 0}
        };
        mesh_setup_t phases[] = '{
            '{1'b1, 20, 30, 4915, 1638, 256, 1'b0, 1'b0},
            '{1'b0, 1023, 1023, 0, 0, 65535, 1'b0, 1'b0},
            '{1'b1, 7, 13, 32767, 32767, 0, 1'b0, 1'b0},
            '{1'b0, 0, 0, 100, 200, 1, 1'b0, 1'b0},
            '{1'b1, 1023, 1, 0, 32767, 65535, 1'b0, 1'b0},
            '{1'b1, 20, 30, 4915, 1638, 256, 1'b1, 1'b1},
            '{1'b0, 3, 1000, 1, 1, 12345, 1'b0, 1'b0},
            '{1'b1, 1, 1023, 16384, 8192, 1, 1'b0, 1'b0}
        };
        grid_row_t g;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        cfg_mode = 1'b0;
        cfg_rows = 20;
        cfg_cols = 30;
        cfg_ring = 4915;
        cfg_tube = 1638;
        cfg_tile = 256;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_point(directed[i]);
        foreach (phases[p])
        begin
            s_tvalid <= 1'b0;
            apply_setup(phases[p]);
            for (int n = 0; n < 130; n++)
            begin
                if (phases[p].hold && n == 20)
                    hold_cycles = 300;
                g.row = pick_index(cfg_rows);
                g.col = pick_index(cfg_cols);
                g.typed = 1'b0;
                send_point(g);
            end
        end
        s_tvalid <= 1'b0;
        while (vertex_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
